FILE: design/gaps_pkg.sv
// Shared types and constants for the grid path search block.
`timescale 1ns / 1ps
package gaps_pkg;
  localparam int unsigned COST_STRAIGHT = 10;
  localparam int unsigned COST_DIAG = 14;
  localparam int unsigned MAX_CELLS = 64;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SCAN,
    ST_SCAN_END,
    ST_EXPAND,
    ST_NB_READ,
    ST_NB_UPDATE,
    ST_TRACE_READ,
    ST_TRACE_STEP,
    ST_EMIT_READ,
    ST_EMIT,
    ST_FAIL
  } state_t;

  typedef struct packed {
    logic [5:0] addr;
    logic       wen;
    logic [9:0] g;
    logic [2:0] dir;
    logic       open;
    logic       closed;
  } node_req_t;

  typedef struct packed {
    logic [9:0] g;
    logic [2:0] dir;
    logic       open;
    logic       closed;
  } node_t;

  function automatic logic signed [1:0] move_dx(input logic [2:0] d);
    case (d)
      3'd0, 3'd1: move_dx = 2'sd0;
      3'd2, 3'd4, 3'd6: move_dx = 2'sd1;
      default: move_dx = -2'sd1;
    endcase
  endfunction

  function automatic logic signed [1:0] move_dy(input logic [2:0] d);
    case (d)
      3'd0, 3'd6, 3'd7: move_dy = -2'sd1;
      3'd2, 3'd3: move_dy = 2'sd0;
      default: move_dy = 2'sd1;
    endcase
  endfunction

  function automatic logic [6:0] octile(input logic [2:0] ax, input logic [2:0] ay,
                                        input logic [2:0] bx, input logic [2:0] by);
    logic [2:0] dx;
    logic [2:0] dy;
    logic [2:0] lo;
    logic [2:0] hi;
    dx = (ax > bx) ? ax - bx : bx - ax;
    dy = (ay > by) ? ay - by : by - ay;
    lo = (dx > dy) ? dy : dx;
    hi = (dx > dy) ? dx : dy;
    octile = 7'(lo * 7'd14) + 7'((hi - lo) * 7'd10);
  endfunction
endpackage

FILE: design/grid_astar_path_search.sv
// Top level of the grid A* path search block.
// Load requests are accepted only while idle. A search clears the node memory, then for each
// expansion scans all 64 cells and tries 8 neighbours, then traces the path back and emits it;
// the single node memory port paces each step.
// One search runs at a time. Reset is synchronous: map all blocked, cell_pixels 16.
`timescale 1ns / 1ps
module grid_astar_path_search #(
  parameter int GRID_W = 8,
  parameter int GRID_H = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  // tdata: cell_x[2:0], cell_y[5:3], walkable[6], goal_x[9:7], goal_y[12:10]
  input  logic [15:0] s_tdata,
  // tuser: kind
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // tdata: path_x[10:0], path_y[21:11], found[22]
  output logic [23:0] m_tdata,
  output logic        m_tlast
);
  import gaps_pkg::*;

  localparam logic [6:0] CELLS_C = 7'(MAX_CELLS);

  state_t state, state_next;
  logic [7:0] cell_pixels;
  logic [2:0] sx, sy, gx, gy;
  logic [6:0] cnt, cnt_next;
  logic [5:0] best, best_next;
  logic       have_best, have_best_next;
  logic [10:0] bf, bf_next;
  logic [6:0] bh, bh_next;
  logic [9:0] bg, bg_next;
  logic [2:0] bd, bd_next;
  logic [3:0] dir, dir_next;
  logic [5:0] nc, nc_next;
  logic [5:0] cur, cur_next;
  logic [6:0] plen, plen_next;
  logic [6:0] iter, iter_next;
  logic [5:0] trail [MAX_CELLS];
  logic       trail_we;
  logic [5:0] trail_rd;
  logic [5:0] trail_addr;
  node_req_t  req;
  node_t      nd;
  logic       walk_bit;
  logic [5:0] walk_raddr;
  logic       out_valid, out_valid_next, out_last, out_last_next, out_found, out_found_next;
  logic [10:0] out_x, out_x_next, out_y, out_y_next;

  logic [2:0] in_x, in_y, in_gx, in_gy;
  logic       load_ok;
  assign in_x = s_tdata[2:0];
  assign in_y = s_tdata[5:3];
  assign in_gx = s_tdata[9:7];
  assign in_gy = s_tdata[12:10];
  assign load_ok = s_tvalid && s_tready && !s_tuser &&
                   (32'(in_x) < GRID_W) && (32'(in_y) < GRID_H);

  gaps_walk_ram u_walk (
    .clk(clk), .rst(rst), .wen(load_ok), .waddr({in_y, in_x}),
    .wdata(s_tdata[6]), .raddr(walk_raddr), .rdata(walk_bit)
  );

  gaps_node_ram u_node (.clk(clk), .req(req), .rdata(nd));

  always_ff @(posedge clk) begin
    if (trail_we) begin
      trail[trail_addr] <= cur;
    end
    trail_rd <= trail[trail_addr];
  end

  function automatic logic [2:0] cx_of(input logic [5:0] c);
    cx_of = c[2:0];
  endfunction
  function automatic logic [2:0] cy_of(input logic [5:0] c);
    cy_of = c[5:3];
  endfunction

  logic [6:0] scan_c;
  logic [2:0] scx, scy;
  logic [6:0] sh;
  logic [10:0] sf;
  assign scan_c = cnt - 7'd1;
  assign scx = cx_of(scan_c[5:0]);
  assign scy = cy_of(scan_c[5:0]);
  assign sh = octile(scx, scy, gx, gy);
  assign sf = 11'(nd.g) + 11'(sh);

  logic signed [4:0] nx, ny;
  logic nb_in;
  logic [9:0] ng;
  assign nx = 5'(signed'({1'b0, cx_of(best)})) + 5'(move_dx(dir[2:0]));
  assign ny = 5'(signed'({1'b0, cy_of(best)})) + 5'(move_dy(dir[2:0]));
  assign nb_in = (nx >= 0) && (ny >= 0) && (32'(nx) < GRID_W) && (32'(ny) < GRID_H);
  assign ng = bg + ((dir < 4'd4) ? 10'(COST_STRAIGHT) : 10'(COST_DIAG));

  logic signed [4:0] px, py;
  assign px = 5'(signed'({1'b0, cx_of(cur)})) - 5'(move_dx(nd.dir));
  assign py = 5'(signed'({1'b0, cy_of(cur)})) - 5'(move_dy(nd.dir));

  logic [18:0] prod_x, prod_y;
  assign prod_x = 19'(cx_of(trail_rd)) * 19'(cell_pixels);
  assign prod_y = 19'(cy_of(trail_rd)) * 19'(cell_pixels);

  logic out_free;
  assign out_free = !out_valid || m_tready;
  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cell_pixels <= 8'd16;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
      if (cfg_we) begin
        cell_pixels <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready && s_tuser) begin
      sx <= in_x;
      sy <= in_y;
      gx <= in_gx;
      gy <= in_gy;
    end
    cnt <= cnt_next;
    best <= best_next;
    have_best <= have_best_next;
    bf <= bf_next;
    bh <= bh_next;
    bg <= bg_next;
    bd <= bd_next;
    dir <= dir_next;
    nc <= nc_next;
    cur <= cur_next;
    plen <= plen_next;
    iter <= iter_next;
    out_x <= out_x_next;
    out_y <= out_y_next;
    out_found <= out_found_next;
    out_last <= out_last_next;
  end

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    best_next = best;
    have_best_next = have_best;
    bf_next = bf;
    bh_next = bh;
    bg_next = bg;
    bd_next = bd;
    dir_next = dir;
    nc_next = nc;
    cur_next = cur;
    plen_next = plen;
    iter_next = iter;
    out_valid_next = out_valid && !m_tready;
    out_x_next = out_x;
    out_y_next = out_y;
    out_found_next = out_found;
    out_last_next = out_last;
    req = '0;
    walk_raddr = nc;
    trail_we = 1'b0;
    trail_addr = 6'(plen);
    case (state)
      ST_IDLE: begin
        cnt_next = '0;
        if (s_tvalid && s_tuser) begin
          state_next = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        req.addr = cnt[5:0];
        req.wen = 1'b1;
        req.open = (cnt[5:0] == {sy, sx});
        cnt_next = cnt + 7'd1;
        if (cnt == CELLS_C - 7'd1) begin
          if ((32'(sx) >= GRID_W) || (32'(sy) >= GRID_H) ||
              (32'(gx) >= GRID_W) || (32'(gy) >= GRID_H)) begin
            state_next = ST_FAIL;
          end else begin
            state_next = ST_EXPAND;
            iter_next = '0;
            dir_next = 4'd8;
          end
        end
      end
      ST_EXPAND: begin
        cnt_next = 7'd1;
        have_best_next = 1'b0;
        req.addr = 6'd0;
        if (iter == CELLS_C) begin
          state_next = ST_FAIL;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (nd.open && (!have_best || sf < bf || (sf == bf && sh < bh))) begin
          have_best_next = 1'b1;
          best_next = scan_c[5:0];
          bf_next = sf;
          bh_next = sh;
          bg_next = nd.g;
          bd_next = nd.dir;
        end
        req.addr = cnt[5:0];
        cnt_next = cnt + 7'd1;
        if (cnt == CELLS_C) begin
          state_next = ST_SCAN_END;
        end
      end
      ST_SCAN_END: begin
        iter_next = iter + 7'd1;
        if (!have_best) begin
          state_next = ST_FAIL;
        end else begin
          req.addr = best;
          req.wen = 1'b1;
          req.g = bg;
          req.dir = bd;
          req.closed = 1'b1;
          if (best == {gy, gx}) begin
            cur_next = best;
            plen_next = '0;
            state_next = ST_TRACE_READ;
          end else begin
            dir_next = '0;
            state_next = ST_NB_READ;
          end
        end
      end
      ST_NB_READ: begin
        if (dir == 4'd8) begin
          state_next = ST_EXPAND;
        end else if (!nb_in) begin
          dir_next = dir + 4'd1;
        end else begin
          nc_next = {ny[2:0], nx[2:0]};
          walk_raddr = {ny[2:0], nx[2:0]};
          req.addr = {ny[2:0], nx[2:0]};
          state_next = ST_NB_UPDATE;
        end
      end
      ST_NB_UPDATE: begin
        req.addr = nc;
        if (walk_bit && !nd.closed && (!nd.open || ng < nd.g)) begin
          req.wen = 1'b1;
          req.g = ng;
          req.dir = dir[2:0];
          req.open = 1'b1;
        end
        dir_next = dir + 4'd1;
        state_next = ST_NB_READ;
      end
      ST_TRACE_READ: begin
        req.addr = cur;
        state_next = ST_TRACE_STEP;
      end
      ST_TRACE_STEP: begin
        trail_we = 1'b1;
        plen_next = plen + 7'd1;
        if (cur == {sy, sx} || plen == CELLS_C - 7'd1 ||
            px < 0 || py < 0 || 32'(px) >= GRID_W || 32'(py) >= GRID_H) begin
          state_next = ST_EMIT_READ;
        end else begin
          cur_next = {py[2:0], px[2:0]};
          state_next = ST_TRACE_READ;
        end
      end
      ST_EMIT_READ: begin
        trail_addr = 6'(plen - 7'd1);
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        trail_addr = 6'(plen - 7'd1);
        if (out_free) begin
          out_valid_next = 1'b1;
          out_x_next = prod_x[10:0];
          out_y_next = prod_y[10:0];
          out_found_next = 1'b1;
          out_last_next = (plen == 7'd1);
          plen_next = plen - 7'd1;
          state_next = (plen == 7'd1) ? ST_IDLE : ST_EMIT_READ;
        end
      end
      ST_FAIL: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_x_next = '0;
          out_y_next = '0;
          out_found_next = 1'b0;
          out_last_next = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign m_tvalid = out_valid;
  assign m_tdata = {1'b0, out_found, out_y, out_x};
  assign m_tlast = out_last;

`ifndef SYNTHESIS
  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (state == ST_IDLE)) else $error("ready outside idle");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> ($stable(m_tdata) && m_tvalid)) else $error("result dropped");
  a_fail_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[22]) |-> m_tlast) else $error("no-path result without last");
`endif
endmodule

FILE: design/gaps_node_ram.sv
// Per-cell search node memory: cost, parent move, open and closed flags.
`timescale 1ns / 1ps
module gaps_node_ram (
  input  logic               clk,
  input  gaps_pkg::node_req_t req,
  output gaps_pkg::node_t    rdata
);
  import gaps_pkg::*;

  node_t mem [MAX_CELLS];

  always_ff @(posedge clk) begin
    if (req.wen) begin
      mem[req.addr] <= '{g: req.g, dir: req.dir, open: req.open, closed: req.closed};
    end
    rdata <= mem[req.addr];
  end
endmodule

FILE: design/gaps_walk_ram.sv
// Walkable bit map with valid bits cleared at reset.
`timescale 1ns / 1ps
module gaps_walk_ram (
  input  logic       clk,
  input  logic       rst,
  input  logic       wen,
  input  logic [5:0] waddr,
  input  logic       wdata,
  input  logic [5:0] raddr,
  output logic       rdata
);
  import gaps_pkg::*;

  logic bits [MAX_CELLS];
  logic [MAX_CELLS-1:0] valid;

  always_ff @(posedge clk) begin
    if (wen) begin
      bits[waddr] <= wdata;
    end
    rdata <= bits[raddr] & valid[raddr] & !rst;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wen) begin
      valid[waddr] <= 1'b1;
    end
  end
endmodule
